### rtl/swbs_pkg.sv
// Shared types and codes for the sliding window block sender.
package swbs_pkg;

    localparam int BLOCK_W = 32;

    localparam logic [BLOCK_W-1:0] TAG_EMPTY = '1;

    // request opcodes
    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_REPLY = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_ABORT = 2'd3;

    // reply kinds; the last code is not a valid reply
    localparam logic [1:0] RK_ACK = 2'd0;
    localparam logic [1:0] RK_NAK = 2'd1;
    localparam logic [1:0] RK_SYN = 2'd2;
    localparam logic [1:0] RK_BAD = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_START_OFFSET = 2'd0;
    localparam logic [1:0] REG_TOTAL_BLOCKS = 2'd1;
    localparam logic [1:0] REG_RESEND_LIMIT = 2'd2;
    localparam logic [1:0] REG_ABORT_LIMIT  = 2'd3;

    // action codes of a result
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_TRANSMIT = 2'd1;
    localparam logic [1:0] ACT_FINISHED = 2'd2;

    // protocol state codes as reported in a result
    localparam logic [2:0] PS_START = 3'd0;
    localparam logic [2:0] PS_SEND  = 3'd1;
    localparam logic [2:0] PS_CHECK = 3'd2;
    localparam logic [2:0] PS_ABORT = 3'd3;
    localparam logic [2:0] PS_END   = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic [BLOCK_W-1:0] send_block;
        logic               fresh_read;
        logic [2:0]         protocol_state;
    } result_t;

endpackage

### rtl/swbs_ring.sv
// Resend ring: block tags, hit check and tag write at block mod slot count.
module swbs_ring
    import swbs_pkg::*;
#(
    parameter int WINDOW_SLOTS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [BLOCK_W-1:0] blk,
    input  logic               wr,
    output logic               hit
);

    localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int RW     = SLOT_W + 1;
    localparam logic [RW-1:0] SLOTS_R = RW'(WINDOW_SLOTS);

    logic [BLOCK_W-1:0] tag_reg [WINDOW_SLOTS];
    logic [RW-1:0]      pw [BLOCK_W];
    logic [SLOT_W-1:0]  slot;

    // residue of 2^b for each bit of the block number
    for (genvar b = 0; b < BLOCK_W; b++) begin : g_pw
        localparam logic [RW-1:0] PWB = RW'((64'd1 << b) % WINDOW_SLOTS);
        assign pw[b] = PWB;
    end

    // blk mod slots: modular add tree over the per-bit residues
    always_comb
    begin
        logic [RW-1:0] lv [6][BLOCK_W];
        logic [RW-1:0] s;
        for (int l = 0; l < 6; l++)
        begin
            for (int i = 0; i < BLOCK_W; i++)
            begin
                lv[l][i] = '0;
            end
        end
        for (int i = 0; i < BLOCK_W; i++)
        begin
            lv[0][i] = blk[i] ? pw[i] : '0;
        end
        for (int l = 0; l < 5; l++)
        begin
            for (int i = 0; i < BLOCK_W / 2; i++)
            begin
                if (i < ((BLOCK_W / 2) >> l))
                begin
                    s = lv[l][2*i] + lv[l][2*i+1];
                    lv[l+1][i] = (s >= SLOTS_R) ? s - SLOTS_R : s;
                end
            end
        end
        slot = lv[5][0][SLOT_W-1:0];
    end

    // a tag only ever sits in its own slot, so any matching slot is the right one
    always_comb
    begin
        hit = 1'b0;
        for (int j = 0; j < WINDOW_SLOTS; j++)
        begin
            if (tag_reg[j] == blk)
            begin
                hit = 1'b1;
            end
        end
        if (blk == TAG_EMPTY)
        begin
            hit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WINDOW_SLOTS; j++)
            begin
                tag_reg[j] <= TAG_EMPTY;
            end
        end
        else if (wr)
        begin
            tag_reg[slot] <= blk;
        end
    end

endmodule

### rtl/swbs_core.sv
// Protocol state, counters, timers and configuration; computes one result per request.
module swbs_core
    import swbs_pkg::*;
#(
    parameter int WINDOW_SLOTS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_acc,
    input  logic [1:0]         opcode,
    input  logic [1:0]         reply_kind,
    input  logic [BLOCK_W-1:0] reply_block,
    input  logic               ring_hit,
    output logic               ring_wr,
    output logic [BLOCK_W-1:0] cur_block,
    output result_t            result
);

    typedef enum logic [2:0] {
        PH_START = PS_START,
        PH_SEND  = PS_SEND,
        PH_CHECK = PS_CHECK,
        PH_ABORT = PS_ABORT,
        PH_END   = PS_END
    } phase_t;

    typedef struct packed {
        logic               ok;
        logic               skip;
        logic [BLOCK_W-1:0] cur;
    } adv_t;

    localparam logic [15:0] RESEND_LIMIT_RST = 16'd100;
    localparam logic [15:0] ABORT_LIMIT_RST  = 16'd1000;
    localparam logic [15:0] TIMER_MAX        = 16'hFFFF;
    localparam logic [BLOCK_W-1:0] FILL_LIMIT = BLOCK_W'(WINDOW_SLOTS);

    logic [31:0]        start_offset_reg;
    logic [31:0]        total_blocks_reg;
    logic [15:0]        resend_limit_reg;
    logic [15:0]        abort_limit_reg;

    phase_t             phase_reg, phase_next;
    logic [BLOCK_W-1:0] completed_reg, completed_next;
    logic [BLOCK_W-1:0] current_reg, current_next;
    logic [BLOCK_W-1:0] read_count_reg, read_count_next;
    logic [15:0]        resend_timer_reg, resend_timer_next;
    logic [15:0]        abort_timer_reg, abort_timer_next;
    logic               tag_wr;

    // guard: while in abort only a change to end is taken
    function automatic phase_t go(input phase_t cur, input phase_t nxt);
        return (cur != PH_ABORT || nxt == PH_END) ? nxt : cur;
    endfunction

    // jump past the read position while blocks still remain
    function automatic logic skip_to(input logic [BLOCK_W-1:0] pos,
                                     input logic [BLOCK_W-1:0] rdc,
                                     input logic [31:0] off,
                                     input logic [31:0] tot);
        return ({1'b0, pos} > ({1'b0, rdc} + 33'd1)) &&
               (({1'b0, rdc} + {1'b0, off}) < {1'b0, tot});
    endfunction

    function automatic logic blocks_left(input logic [BLOCK_W-1:0] blk,
                                         input logic [31:0] off,
                                         input logic [31:0] tot);
        return ({1'b0, blk} + {1'b0, off}) < {1'b0, tot};
    endfunction

    // window advance; the position moves even when the move is a skip
    function automatic adv_t advance(input logic [BLOCK_W-1:0] cur,
                                     input logic [BLOCK_W-1:0] rdc,
                                     input logic [BLOCK_W-1:0] comp,
                                     input phase_t ph,
                                     input logic [31:0] off,
                                     input logic [31:0] tot);
        adv_t a;
        logic [BLOCK_W-1:0] fill;
        fill   = rdc - comp;
        a.ok   = 1'b0;
        a.skip = 1'b0;
        a.cur  = cur;
        if (($signed(fill) < $signed(FILL_LIMIT)) && ph != PH_ABORT)
        begin
            a.cur  = cur + 1'b1;
            a.skip = skip_to(a.cur, rdc, off, tot);
            a.ok   = !a.skip;
        end
        return a;
    endfunction

    always_comb
    begin
        phase_t             ph;
        logic [BLOCK_W-1:0] comp, cur, rdc, sblk, pos;
        logic [15:0]        rt, at;
        logic [1:0]         act;
        logic               fresh, wr, do_check, more;
        adv_t               a;

        ph       = phase_reg;
        comp     = completed_reg;
        cur      = current_reg;
        rdc      = read_count_reg;
        rt       = resend_timer_reg;
        at       = abort_timer_reg;
        act      = ACT_NONE;
        sblk     = '0;
        fresh    = 1'b0;
        wr       = 1'b0;
        do_check = 1'b0;
        more     = 1'b0;
        pos      = '0;
        a        = '0;

        if (phase_reg != PH_END)
        begin
            if (opcode == OP_ABORT)
            begin
                ph = go(ph, PH_ABORT);
            end
            unique case (ph)
                PH_START:
                begin
                    if (opcode == OP_START)
                    begin
                        ph = go(ph, PH_SEND);
                    end
                end
                PH_SEND:
                begin
                    if (!ring_hit)
                    begin
                        wr = 1'b1;
                        if (rdc > cur)
                        begin
                            ph = go(ph, PH_END);
                        end
                        else
                        begin
                            rdc = rdc + 1'b1;
                        end
                    end
                    act   = ACT_TRANSMIT;
                    sblk  = cur;
                    fresh = !ring_hit;
                    rt    = '0;
                    ph    = go(ph, PH_CHECK);
                end
                PH_ABORT:
                begin
                    if (at < abort_limit_reg && (rdc - comp) != BLOCK_W'(1))
                    begin
                        at       = at + 1'b1;
                        do_check = 1'b1;
                    end
                    else
                    begin
                        ph = go(ph, PH_END);
                    end
                end
                PH_CHECK:
                begin
                    do_check = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (do_check)
            begin
                if (opcode == OP_REPLY &&
                    (reply_kind == RK_ACK || reply_kind == RK_NAK || reply_kind == RK_SYN))
                begin
                    case (reply_kind)
                        RK_ACK:
                        begin
                            comp = reply_block;
                            more = blocks_left(reply_block, start_offset_reg,
                                               total_blocks_reg);
                            if (!more)
                            begin
                                ph = go(ph, PH_END);
                                ph = go(ph, PH_END);
                            end
                            else if (reply_block <= cur)
                            begin
                                a = advance(cur, rdc, comp, ph, start_offset_reg,
                                            total_blocks_reg);
                                cur = a.cur;
                                if (a.skip)
                                begin
                                    ph = go(ph, PH_END);
                                end
                                ph = go(ph, a.ok ? PH_SEND : PH_CHECK);
                            end
                            else if (skip_to(reply_block, rdc, start_offset_reg,
                                             total_blocks_reg))
                            begin
                                ph = go(ph, PH_END);
                                ph = go(ph, PH_ABORT);
                            end
                            else
                            begin
                                cur = reply_block;
                                ph  = go(ph, PH_SEND);
                            end
                        end
                        RK_SYN:
                        begin
                            pos = reply_block + 1'b1;
                            if (skip_to(pos, rdc, start_offset_reg, total_blocks_reg))
                            begin
                                ph = go(ph, PH_END);
                                ph = go(ph, PH_ABORT);
                            end
                            else
                            begin
                                cur  = pos;
                                comp = reply_block;
                                more = blocks_left(reply_block, start_offset_reg,
                                                   total_blocks_reg);
                                if (!more)
                                begin
                                    ph = go(ph, PH_END);
                                end
                                ph = go(ph, more ? PH_SEND : PH_END);
                            end
                        end
                        default:
                        begin
                            // NAK
                            if (skip_to(reply_block, rdc, start_offset_reg,
                                        total_blocks_reg))
                            begin
                                ph = go(ph, PH_END);
                                ph = go(ph, PH_ABORT);
                            end
                            else
                            begin
                                cur = reply_block;
                                ph  = go(ph, PH_SEND);
                            end
                        end
                    endcase
                end
                else
                begin
                    // poll, start, abort, or a reply of unknown kind
                    a = advance(cur, rdc, comp, ph, start_offset_reg, total_blocks_reg);
                    cur = a.cur;
                    if (a.skip)
                    begin
                        ph = go(ph, PH_END);
                    end
                    if (a.ok)
                    begin
                        ph = go(ph, PH_SEND);
                    end
                    else if (rt > resend_limit_reg)
                    begin
                        ph = go(ph, PH_SEND);
                        rt = '0;
                    end
                    else
                    begin
                        if (rt != TIMER_MAX)
                        begin
                            rt = rt + 1'b1;
                        end
                        ph = go(ph, PH_CHECK);
                    end
                end
            end
        end

        if (act == ACT_NONE && ph == PH_END)
        begin
            act = ACT_FINISHED;
        end

        phase_next        = ph;
        completed_next    = comp;
        current_next      = cur;
        read_count_next   = rdc;
        resend_timer_next = rt;
        abort_timer_next  = at;
        tag_wr            = wr;

        result.action         = act;
        result.send_block     = sblk;
        result.fresh_read     = fresh;
        result.protocol_state = ph;
    end

    assign ring_wr   = tag_wr & in_acc;
    assign cur_block = current_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= '0;
            total_blocks_reg <= '0;
            resend_limit_reg <= RESEND_LIMIT_RST;
            abort_limit_reg  <= ABORT_LIMIT_RST;
            phase_reg        <= PH_START;
            completed_reg    <= '0;
            current_reg      <= '0;
            read_count_reg   <= '0;
            resend_timer_reg <= '0;
            abort_timer_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_OFFSET: start_offset_reg <= cfg_data;
                    REG_TOTAL_BLOCKS: total_blocks_reg <= cfg_data;
                    REG_RESEND_LIMIT: resend_limit_reg <= cfg_data[15:0];
                    REG_ABORT_LIMIT:  abort_limit_reg  <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_acc)
            begin
                phase_reg        <= phase_next;
                completed_reg    <= completed_next;
                current_reg      <= current_next;
                read_count_reg   <= read_count_next;
                resend_timer_reg <= resend_timer_next;
                abort_timer_reg  <= abort_timer_next;
            end
        end
    end

endmodule

### rtl/swbs_outq.sv
// Two-entry result buffer: output register plus skid register.
module swbs_outq
    import swbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    take;

    assign take = out_valid_reg & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_reg <= push_data;
            end
            else
            begin
                skid_data_reg <= push_data;
            end
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/sliding_window_block_sender_top.sv
// Top level of the sliding window block sender.
// Each accepted request (poll, reply, start token or abort) is one pass of the
// sender loop and yields exactly one result, shown on out_valid the cycle after
// acceptance unless an earlier result is still waiting to be taken. A new request
// is taken every cycle: the whole step is one pass of
// compares and 33-bit adds between the state registers and a two-entry result
// buffer, so in_stall rises only when both buffer entries hold results that the
// receiver has not taken. The resend ring keeps WINDOW_SLOTS block tags in
// flip-flops, checked in parallel; reset marks every slot empty at once.
// Configuration is to be written through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module sliding_window_block_sender_top
    import swbs_pkg::*;
#(
    parameter int WINDOW_SLOTS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [1:0]         reply_kind,
    input  logic [BLOCK_W-1:0] reply_block,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         action,
    output logic [BLOCK_W-1:0] send_block,
    output logic               fresh_read,
    output logic [2:0]         protocol_state
);

    logic               in_acc;
    logic               ring_hit;
    logic               ring_wr;
    logic [BLOCK_W-1:0] cur_block;
    result_t            step_result;
    result_t            out_data;

    assign in_acc = in_valid & ~in_stall;

    swbs_core #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_acc     (in_acc),
        .opcode     (opcode),
        .reply_kind (reply_kind),
        .reply_block(reply_block),
        .ring_hit   (ring_hit),
        .ring_wr    (ring_wr),
        .cur_block  (cur_block),
        .result     (step_result)
    );

    swbs_ring #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) u_ring (
        .clk  (clk),
        .rst_n(rst_n),
        .blk  (cur_block),
        .wr   (ring_wr),
        .hit  (ring_hit)
    );

    swbs_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_acc),
        .push_data(step_result),
        .full     (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    assign action         = out_data.action;
    assign send_block     = out_data.send_block;
    assign fresh_read     = out_data.fresh_read;
    assign protocol_state = out_data.protocol_state;

endmodule

### rtl/swbs_checker.sv
// Port-level checks for the sliding window block sender, bound to the top level.
module swbs_checker
    import swbs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         action,
    input logic [BLOCK_W-1:0] send_block,
    input logic               fresh_read,
    input logic [2:0]         protocol_state
);

    logic ended_reg;

    // set once a result reporting the end state has been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ended_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && protocol_state == PS_END)
        begin
            ended_reg <= 1'b1;
        end
    end

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ended_reg |-> action == ACT_FINISHED && protocol_state == PS_END)
        else $error("result after end is not a finished result");

    a_send_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_TRANSMIT |->
            protocol_state == PS_CHECK || protocol_state == PS_END)
        else $error("transmit result left the protocol outside check or end");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_TRANSMIT |-> send_block == '0 && !fresh_read)
        else $error("block fields set on a result that sends nothing");

    a_stall_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("request stalled with no result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action) &&
            $stable(send_block) && $stable(fresh_read) && $stable(protocol_state))
        else $error("stalled result changed");

endmodule

bind sliding_window_block_sender_top swbs_checker u_swbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .send_block    (send_block),
    .fresh_read    (fresh_read),
    .protocol_state(protocol_state)
);

### tb/sv/sliding_window_block_sender_top_tb.sv
// Testbench for the sliding window block sender: stepped predictor, random handshakes.
module sliding_window_block_sender_top_tb
    import swbs_pkg::*;
();

    localparam int SLOTS = 4;
    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LIMIT = 5000;

    typedef enum {MIX_WINDOW, MIX_FAR, MIX_POLLS, MIX_ANY} mix_t;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [31:0] blk;
    } loop_event_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = 2'd0;
    logic [31:0]        cfg_data = 32'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = 2'd0;
    logic [1:0]         reply_kind = 2'd0;
    logic [BLOCK_W-1:0] reply_block = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         action;
    logic [BLOCK_W-1:0] send_block;
    logic               fresh_read;
    logic [2:0]         protocol_state;

    // sender state as predicted
    logic [2:0]  ps;
    logic [31:0] done_cnt, cur_blk, rd_cnt;
    logic [15:0] rs_tmr, ab_tmr;
    logic [31:0] slot_tags [SLOTS];
    logic [31:0] cfg_offset, cfg_total;
    logic [15:0] cfg_resend_lim, cfg_abort_lim;

    loop_event_t loop_events [$];
    result_t     loop_results [$];
    loop_event_t next_ev;
    result_t     want;

    int fail_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_wanted = 0;
    int holdoff_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    sliding_window_block_sender_top #(.WINDOW_SLOTS(SLOTS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .reply_kind(reply_kind),
        .reply_block(reply_block),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .action(action),
        .send_block(send_block),
        .fresh_read(fresh_read),
        .protocol_state(protocol_state)
    );

    always #5 clk = ~clk;

    function automatic void reset_model();
        ps = PS_START;
        done_cnt = '0;
        cur_blk = '0;
        rd_cnt = '0;
        rs_tmr = '0;
        ab_tmr = '0;
        for (int i = 0; i < SLOTS; i++)
            slot_tags[i] = TAG_EMPTY;
        cfg_offset = '0;
        cfg_total = '0;
        cfg_resend_lim = 16'd100;
        cfg_abort_lim = 16'd1000;
    endfunction

    // while draining after an abort, only the move to end is taken
    function automatic void set_phase(logic [2:0] nxt);
        if (ps != PS_ABORT || nxt == PS_END)
            ps = nxt;
    endfunction

    function automatic bit complete_upto(logic [31:0] blk);
        done_cnt = blk;
        if ({1'b0, done_cnt} + {1'b0, cfg_offset} >= {1'b0, cfg_total})
        begin
            set_phase(PS_END);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit jump_to(logic [31:0] pos);
        if ({1'b0, pos} > {1'b0, rd_cnt} + 33'd1 &&
            {1'b0, rd_cnt} + {1'b0, cfg_offset} < {1'b0, cfg_total})
        begin
            set_phase(PS_END);
            return 1'b0;
        end
        cur_blk = pos;
        return 1'b1;
    endfunction

    function automatic bit slide_window();
        logic signed [31:0] fill;
        fill = rd_cnt - done_cnt;
        if (fill < SLOTS && ps != PS_ABORT)
        begin
            cur_blk = cur_blk + 32'd1;
            return jump_to(cur_blk);
        end
        return 1'b0;
    endfunction

    function automatic void handle_check(logic [1:0] op, logic [1:0] kind, logic [31:0] rb);
        if (op == OP_REPLY && kind != RK_BAD)
        begin
            if (kind == RK_ACK)
            begin
                if (complete_upto(rb))
                begin
                    if (rb <= cur_blk)
                    begin
                        if (slide_window())
                            set_phase(PS_SEND);
                        else
                            set_phase(PS_CHECK);
                    end
                    else if (jump_to(rb))
                        set_phase(PS_SEND);
                    else
                        set_phase(PS_ABORT);
                end
                else
                    set_phase(PS_END);
            end
            else if (kind == RK_SYN)
            begin
                if (jump_to(rb + 32'd1))
                begin
                    if (complete_upto(rb))
                        set_phase(PS_SEND);
                    else
                        set_phase(PS_END);
                end
                else
                    set_phase(PS_ABORT);
            end
            else if (jump_to(rb))
                set_phase(PS_SEND);
            else
                set_phase(PS_ABORT);
        end
        else
        begin
            if (slide_window())
                set_phase(PS_SEND);
            else if (rs_tmr > cfg_resend_lim)
            begin
                set_phase(PS_SEND);
                rs_tmr = '0;
            end
            else
            begin
                if (rs_tmr != 16'hFFFF)
                    rs_tmr = rs_tmr + 16'd1;
                set_phase(PS_CHECK);
            end
        end
    endfunction

    // one pass of the sender loop for one accepted request
    function automatic result_t sender_loop_pass(logic [1:0] op, logic [1:0] kind,
                                                 logic [31:0] rb);
        result_t     r;
        logic [31:0] blk;
        int          slot;
        bit          hit;
        r = '0;
        r.action = ACT_NONE;
        if (ps != PS_END)
        begin
            if (op == OP_ABORT)
                set_phase(PS_ABORT);
            case (ps)
                PS_START:
                begin
                    if (op == OP_START)
                        set_phase(PS_SEND);
                end
                PS_SEND:
                begin
                    blk = cur_blk;
                    slot = int'(blk % SLOTS);
                    hit = (slot_tags[slot] == blk) && (blk != TAG_EMPTY);
                    if (!hit)
                    begin
                        slot_tags[slot] = blk;
                        if (rd_cnt > blk)
                            set_phase(PS_END);
                        else
                            rd_cnt = rd_cnt + 32'd1;
                    end
                    r.action = ACT_TRANSMIT;
                    r.send_block = blk;
                    r.fresh_read = !hit;
                    rs_tmr = '0;
                    set_phase(PS_CHECK);
                end
                PS_ABORT:
                begin
                    if (ab_tmr < cfg_abort_lim && (rd_cnt - done_cnt) != 32'd1)
                    begin
                        ab_tmr = ab_tmr + 16'd1;
                        handle_check(op, kind, rb);
                    end
                    else
                        set_phase(PS_END);
                end
                PS_CHECK: handle_check(op, kind, rb);
                default: ;
            endcase
        end
        if (r.action == ACT_NONE && ps == PS_END)
            r.action = ACT_FINISHED;
        r.protocol_state = ps;
        return r;
    endfunction

    // window-mix replies stay at most one past the read count so no skip ends the transfer early
    function automatic loop_event_t pick_event(mix_t mix);
        loop_event_t ev;
        int          roll;
        logic [31:0] lo;
        roll = $urandom_range(99);
        ev.op = OP_POLL;
        ev.kind = 2'($urandom_range(3));
        ev.blk = $urandom;
        lo = (rd_cnt > 32'd4) ? rd_cnt - 32'd4 : 32'd0;
        case (mix)
            MIX_WINDOW:
            begin
                if (roll < 40)
                begin
                    ev.op = OP_REPLY;
                    ev.kind = RK_ACK;
                    ev.blk = $urandom_range(rd_cnt + 32'd1, lo);
                end
                else if (roll < 55)
                begin
                    ev.op = OP_REPLY;
                    ev.kind = RK_NAK;
                    ev.blk = $urandom_range(rd_cnt + 32'd1, lo);
                end
                else if (roll < 62)
                begin
                    ev.op = OP_REPLY;
                    ev.kind = RK_SYN;
                    ev.blk = $urandom_range(rd_cnt, lo);
                end
                else if (roll < 66)
                begin
                    ev.op = OP_REPLY;
                    ev.kind = RK_ACK;
                    ev.blk = $urandom_range(rd_cnt, 0);
                end
                else if (roll >= 88)
                begin
                    ev.op = (roll < 94) ? OP_START : OP_REPLY;
                    if (ev.op == OP_REPLY)
                        ev.kind = RK_BAD;
                end
            end
            MIX_FAR:
            begin
                if (roll < 45)
                begin
                    ev.op = OP_REPLY;
                    ev.kind = RK_NAK;
                    if (roll < 5)
                        ev.blk = TAG_EMPTY;
                end
                else if (roll >= 85)
                begin
                    ev.op = (roll < 92) ? OP_START : OP_REPLY;
                    if (ev.op == OP_REPLY)
                        ev.kind = RK_BAD;
                end
            end
            MIX_ANY: ev.op = 2'($urandom_range(3));
            default: ;
        endcase
        return ev;
    endfunction

    task automatic queue_event(logic [1:0] op, logic [1:0] kind, logic [31:0] blk);
        loop_event_t ev;
        ev.op = op;
        ev.kind = kind;
        ev.blk = blk;
        loop_events.push_back(ev);
    endtask

    task automatic feed(mix_t mix, int count);
        for (int i = 0; i < count; i++)
        begin
            while (loop_events.size() >= 4)
                @(posedge clk);
            loop_events.push_back(pick_event(mix));
        end
    endtask

    // every request has exactly one result, so an empty result queue means idle
    task automatic drain();
        while (loop_events.size() != 0 || in_valid || loop_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_OFFSET: cfg_offset = val;
            REG_TOTAL_BLOCKS: cfg_total = val;
            REG_RESEND_LIMIT: cfg_resend_lim = val[15:0];
            REG_ABORT_LIMIT:  cfg_abort_lim = val[15:0];
            default: ;
        endcase
    endtask

    task automatic check_field(string what, logic [31:0] exp_val, logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_val, got_val);
            fail_cnt++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= OP_POLL;
            reply_kind <= RK_ACK;
            reply_block <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                loop_results.push_back(sender_loop_pass(opcode, reply_kind, reply_block));
            if (!in_valid || !in_stall)
            begin
                if (loop_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_ev = loop_events.pop_front();
                    opcode <= next_ev.op;
                    reply_kind <= next_ev.kind;
                    reply_block <= next_ev.blk;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (loop_results.size() == 0)
                begin
                    $display("%0t: result with none expected, got action %0d block %0h",
                             $time, action, send_block);
                    fail_cnt++;
                end
                else
                begin
                    want = loop_results.pop_front();
                    check_field("action", 32'(want.action), 32'(action));
                    check_field("send_block", want.send_block, send_block);
                    check_field("fresh_read", 32'(want.fresh_read), 32'(fresh_read));
                    check_field("protocol_state", 32'(want.protocol_state),
                                32'(protocol_state));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (holdoff_served != holdoff_wanted)
            begin
                holdoff_served++;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: too long without any accepted request or result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, loop_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_START_OFFSET, 32'd0);
        write_reg(REG_TOTAL_BLOCKS, 32'hFFFF_FFFF);
        write_reg(REG_RESEND_LIMIT, 32'd0);
        write_reg(REG_ABORT_LIMIT, 32'd65535);

        // start phase ignores polls and replies until the start token
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_REPLY, RK_ACK, 32'hFFFF_FFFF);
        queue_event(OP_REPLY, RK_SYN, 32'd0);
        queue_event(OP_REPLY, RK_BAD, 32'hFFFF_FFFF);
        queue_event(OP_START, RK_BAD, 32'hFFFF_FFFF);
        // reply alongside a send is dropped
        queue_event(OP_REPLY, RK_ACK, 32'd5);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_REPLY, RK_NAK, 32'd0);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_START, RK_ACK, 32'd0);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        // window full: resend timer runs out
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_REPLY, RK_NAK, 32'd1);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_REPLY, RK_BAD, 32'd7);
        queue_event(OP_REPLY, RK_ACK, 32'd2);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_REPLY, RK_ACK, 32'd2);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        queue_event(OP_REPLY, RK_SYN, 32'd3);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        // already counted block read again
        queue_event(OP_REPLY, RK_NAK, 32'd0);
        queue_event(OP_POLL, RK_ACK, 32'd0);
        drain();

        // long receiver hold-off while requests keep coming
        feed(MIX_WINDOW, 60);
        holdoff_wanted++;
        feed(MIX_WINDOW, 140);
        drain();

        send_idle_pct = 48;
        write_reg(REG_RESEND_LIMIT, 32'd3);
        write_reg(REG_START_OFFSET, 32'd1000);
        feed(MIX_WINDOW, 400);
        drain();

        // long run of polls with a full window, then a lower limit releases a resend
        send_idle_pct = 0;
        write_reg(REG_RESEND_LIMIT, 32'd65535);
        feed(MIX_POLLS, 150);
        drain();
        write_reg(REG_RESEND_LIMIT, 32'd20);
        feed(MIX_WINDOW, 30);
        drain();

        // no skip possible: far jumps and the all-ones block
        recv_stall_pct = 48;
        write_reg(REG_START_OFFSET, 32'hFFFF_FFFF);
        feed(MIX_FAR, 300);
        drain();

        send_idle_pct = 30;
        recv_stall_pct = 30;
        write_reg(REG_START_OFFSET, 32'd0);
        write_reg(REG_TOTAL_BLOCKS, 32'd0);
        write_reg(REG_ABORT_LIMIT, 32'd0);
        feed(MIX_FAR, 300);
        drain();

        write_reg(REG_TOTAL_BLOCKS, 32'hFFFF_FFFF);
        write_reg(REG_RESEND_LIMIT, 32'd7);
        feed(MIX_WINDOW, 500);
        drain();

        // user abort, drain, then the terminal phase
        write_reg(REG_RESEND_LIMIT, 32'd5);
        write_reg(REG_ABORT_LIMIT, 32'd40);
        queue_event(OP_ABORT, 2'($urandom_range(3)), $urandom);
        feed(MIX_WINDOW, 60);
        feed(MIX_ANY, 40);
        drain();
        repeat (10) @(posedge clk);

        if (fail_cnt == 0 && loop_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
